[rtl/slbm_pkg.sv]
// shared types and constants of the serial-loaded bank mapper
`timescale 1ns / 1ps

package slbm_pkg;

   // bus action codes
   localparam logic [1:0] ACT_CPU_READ = 2'd0;
   localparam logic [1:0] ACT_VID_READ = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_NONE   = 2'd0;
   localparam logic [1:0] STATUS_MAPPED = 2'd1;
   localparam logic [1:0] STATUS_RAM    = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_PRG_BANK_COUNT    = 2'd0;
   localparam logic [1:0] CSR_CHR_BANK_COUNT    = 2'd1;
   localparam logic [1:0] CSR_INITIAL_MIRRORING = 2'd2;

   // reset values and fixed masks
   localparam logic [4:0] SHIFT_RESET     = 5'h10;
   localparam logic [4:0] CTRL_RESET      = 5'h1c;
   localparam logic [4:0] CTRL_MODE_FORCE = 5'h0c;
   localparam logic [5:0] PRG_COUNT_RESET = 6'd2;
   localparam logic [1:0] MIRROR_RESET    = 2'd2;

   // bank number remainder takes one quotient bit per cycle
   localparam logic [2:0] DIV_STEPS = 3'd5;

   // commands from controller to datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic div_step;
      logic commit;
   } slbm_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic clear_last;
      logic div_done;
   } slbm_sts_type;

endpackage

[rtl/slbm_req_if.sv]
// request channel: bus access words into the mapper
`timescale 1ns / 1ps

interface slbm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] bus_address;
   logic [7:0]  write_data;

   modport source (output valid, action, bus_address, write_data, input ready);
   modport sink (input valid, action, bus_address, write_data, output ready);
endinterface

[rtl/slbm_rsp_if.sv]
// response channel: mapping result words out of the mapper
`timescale 1ns / 1ps

interface slbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [18:0] mapped_address;
   logic [7:0]  read_data;
   logic [1:0]  mirroring;

   modport source (output valid, status, mapped_address, read_data, mirroring, input ready);
   modport sink (input valid, status, mapped_address, read_data, mirroring, output ready);
endinterface

[rtl/slbm_csr_if.sv]
// configuration write channel of the mapper
`timescale 1ns / 1ps

interface slbm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/slbm_ctrl.sv]
// sequencing state machine of the mapper
`timescale 1ns / 1ps

module slbm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output slbm_pkg::slbm_cmd_type cmd,
   input  slbm_pkg::slbm_sts_type sts
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   // output register can take a word when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   // commands follow the state
   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/slbm_datapath.sv]
// mapper registers, bank remainder unit, work ram and result register
`timescale 1ns / 1ps

module slbm_datapath #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  logic                   clock,
   input  logic                   reset,
   input  slbm_pkg::slbm_cmd_type cmd,
   output slbm_pkg::slbm_sts_type sts,
   input  logic [1:0]             req_action,
   input  logic [15:0]            req_bus_address,
   input  logic [7:0]             req_write_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data,
   output logic [1:0]             rsp_status,
   output logic [18:0]            rsp_mapped_address,
   output logic [7:0]             rsp_read_data,
   output logic [1:0]             rsp_mirroring
);

   localparam int RamAw = $clog2(WORK_RAM_DEPTH);

   // configuration and mapper registers
   logic [5:0]  prg_count_ff, prg_count_in;
   logic [4:0]  chr_count_ff, chr_count_in;
   logic [4:0]  shift_ff, shift_in;
   logic [4:0]  ctrl_ff, ctrl_in;
   logic [4:0]  vbl_ff, vbl_in;
   logic [4:0]  vbh_ff, vbh_in;
   logic [4:0]  prog_ff, prog_in;
   logic        ram_en_ff, ram_en_in;
   logic [1:0]  mir_ff, mir_in;

   // latched bus word
   logic [1:0]  act_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   // remainder unit
   logic [4:0]  num_ff;
   logic [5:0]  den_ff;
   logic [5:0]  rem_ff, rem_in;
   logic [2:0]  div_cnt_ff;
   logic [6:0]  trial;

   // work ram
   logic [7:0]       ram [WORK_RAM_DEPTH];
   logic [7:0]       ram_q_ff;
   logic [RamAw-1:0] clr_cnt_ff;
   logic             ram_we;
   logic             ram_wr;
   logic [RamAw-1:0] ram_waddr;
   logic [7:0]       ram_wdata;

   // result register
   logic [1:0]  status_ff, status_in;
   logic [18:0] mapped_ff, mapped_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [1:0]  mir_out_ff;

   // operand selection at accept
   logic [5:0]  prg_n;
   logic        prg_big;
   logic [3:0]  bank4;
   logic        use_last;
   logic [4:0]  prg_num;
   logic [4:0]  chr_num;
   logic [4:0]  num_in;
   logic [5:0]  den_in;

   // result address forms
   logic [18:0] prg_mapped;
   logic [18:0] chr_mapped;
   logic [4:0]  shift_next;
   logic        ram_hit;

   // dividend and divisor for the bank number of this word
   always_comb begin
      prg_n    = (prg_count_ff == 6'd0) ? 6'd1 : prg_count_ff;
      prg_big  = (prg_n > 6'd16);
      bank4    = prog_ff[3:0];
      use_last = 1'b0;
      unique case (ctrl_ff[3:2])
         2'd0, 2'd1: bank4 = {prog_ff[3:1], 1'b0};
         2'd2:       bank4 = req_bus_address[14] ? prog_ff[3:0] : 4'd0;
         default:    use_last = req_bus_address[14];
      endcase
      if (use_last) begin
         prg_num = prg_big ? {vbl_ff[4], 4'hf} : 5'(prg_n - 6'd1);
      end else begin
         prg_num = prg_big ? {vbl_ff[4], bank4} : {1'b0, bank4};
      end
      if (ctrl_ff[4]) begin
         chr_num = req_bus_address[12] ? vbh_ff : vbl_ff;
      end else begin
         chr_num = {vbl_ff[4:1], 1'b0};
      end
      num_in = req_action[1] ? chr_num : prg_num;
      den_in = req_action[1] ? {chr_count_ff, 1'b0} : prg_n;
   end

   // one restoring step of the remainder
   assign trial  = {rem_ff, num_ff[4]};
   assign rem_in = (trial >= {1'b0, den_ff}) ? 6'(trial - {1'b0, den_ff}) : trial[5:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff     <= req_action;
         addr_ff    <= req_bus_address;
         data_ff    <= req_write_data;
         num_ff     <= num_in;
         den_ff     <= den_in;
         rem_ff     <= 6'd0;
         div_cnt_ff <= slbm_pkg::DIV_STEPS;
      end else if (cmd.div_step) begin
         num_ff     <= {num_ff[3:0], 1'b0};
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff - 3'd1;
      end
   end

   assign sts.div_done   = (div_cnt_ff == 3'd1);
   assign sts.clear_last = (clr_cnt_ff == RamAw'(WORK_RAM_DEPTH - 1));

   // mapped address forms from the remainder
   assign prg_mapped = ctrl_ff[3] ? {rem_ff[4:0], addr_ff[13:0]}
                                  : {rem_ff[4:0], 14'd0} + 19'(addr_ff[14:0]);
   assign chr_mapped = ctrl_ff[4] ? {1'b0, rem_ff, addr_ff[11:0]}
                                  : {1'b0, rem_ff, 12'd0} + 19'(addr_ff[12:0]);
   assign shift_next = {data_ff[0], shift_ff[4:1]};
   assign ram_hit    = (addr_ff[15:13] == 3'b011);

   // register updates and result of one word
   always_comb begin
      prg_count_in = prg_count_ff;
      chr_count_in = chr_count_ff;
      shift_in     = shift_ff;
      ctrl_in      = ctrl_ff;
      vbl_in       = vbl_ff;
      vbh_in       = vbh_ff;
      prog_in      = prog_ff;
      ram_en_in    = ram_en_ff;
      mir_in       = mir_ff;
      status_in    = slbm_pkg::STATUS_NONE;
      mapped_in    = '0;
      rdata_in     = '0;
      ram_we       = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            slbm_pkg::CSR_PRG_BANK_COUNT:    prg_count_in = csr_data[5:0];
            slbm_pkg::CSR_CHR_BANK_COUNT:    chr_count_in = csr_data[4:0];
            slbm_pkg::CSR_INITIAL_MIRRORING: mir_in = csr_data[1:0];
            default: ;
         endcase
      end
      if (cmd.commit) begin
         if (!act_ff[1]) begin
            if (ram_hit) begin
               status_in = slbm_pkg::STATUS_RAM;
               if (act_ff == slbm_pkg::ACT_CPU_READ) begin
                  rdata_in = ram_en_ff ? ram_q_ff : 8'hff;
               end else begin
                  ram_we = ram_en_ff;
               end
            end else if (addr_ff[15]) begin
               if (act_ff == slbm_pkg::ACT_CPU_READ) begin
                  status_in = slbm_pkg::STATUS_MAPPED;
                  mapped_in = prg_mapped;
               end else if (data_ff[7]) begin
                  shift_in = slbm_pkg::SHIFT_RESET;
                  ctrl_in  = ctrl_ff | slbm_pkg::CTRL_MODE_FORCE;
               end else if (shift_ff[0]) begin
                  // fifth bit: commit to the register picked by the address
                  shift_in = slbm_pkg::SHIFT_RESET;
                  unique case (addr_ff[14:13])
                     2'd0: begin
                        ctrl_in = shift_next;
                        mir_in  = shift_next[1:0];
                     end
                     2'd1: vbl_in = shift_next;
                     2'd2: vbh_in = shift_next;
                     default: begin
                        prog_in   = shift_next;
                        ram_en_in = !shift_next[4];
                     end
                  endcase
               end else begin
                  shift_in = shift_next;
               end
            end
         end else if (addr_ff[15:13] == 3'd0) begin
            if (chr_count_ff == 5'd0) begin
               status_in = slbm_pkg::STATUS_MAPPED;
               mapped_in = 19'(addr_ff);
            end else if (act_ff == slbm_pkg::ACT_VID_READ) begin
               status_in = slbm_pkg::STATUS_MAPPED;
               mapped_in = chr_mapped;
            end
         end
      end
   end

   // mapper state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff <= slbm_pkg::PRG_COUNT_RESET;
         chr_count_ff <= 5'd0;
         shift_ff     <= slbm_pkg::SHIFT_RESET;
         ctrl_ff      <= slbm_pkg::CTRL_RESET;
         vbl_ff       <= 5'd0;
         vbh_ff       <= 5'd0;
         prog_ff      <= 5'd0;
         ram_en_ff    <= 1'b1;
         mir_ff       <= slbm_pkg::MIRROR_RESET;
      end else begin
         prg_count_ff <= prg_count_in;
         chr_count_ff <= chr_count_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         vbl_ff       <= vbl_in;
         vbh_ff       <= vbh_in;
         prog_ff      <= prog_in;
         ram_en_ff    <= ram_en_in;
         mir_ff       <= mir_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= status_in;
         mapped_ff  <= mapped_in;
         rdata_ff   <= rdata_in;
         mir_out_ff <= mir_in;
      end
   end

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + RamAw'(1);
      end
   end

   // work ram: one write port, registered read
   assign ram_wr    = cmd.clear || ram_we;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : addr_ff[RamAw-1:0];
   assign ram_wdata = cmd.clear ? 8'd0 : data_ff;

   always_ff @(posedge clock) begin
      if (ram_wr) begin
         ram[ram_waddr] <= ram_wdata;
      end
      ram_q_ff <= ram[addr_ff[RamAw-1:0]];
   end

   assign rsp_status         = status_ff;
   assign rsp_mapped_address = mapped_ff;
   assign rsp_read_data      = rdata_ff;
   assign rsp_mirroring      = mir_out_ff;

endmodule

[rtl/serial_loaded_bank_mapper_unit.sv]
// serial-loaded bank mapper: one word in, one result word out
// the result is registered at commit, once the output register is free
// one word at a time: accept, 5 bank remainder steps, commit
// a new request is taken while the previous result still waits in the output register
// reset: synchronous; a sweep zeroes the whole work ram, requests wait until done
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_unit #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input logic        clock,
   input logic        reset,
   slbm_req_if.sink   req_if,
   slbm_rsp_if.source rsp_if,
   slbm_csr_if.sink   csr_if
);

   slbm_pkg::slbm_cmd_type cmd;
   slbm_pkg::slbm_sts_type sts;

   // configuration writes are always taken
   assign csr_if.ready = 1'b1;

   slbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   slbm_datapath #(
      .WORK_RAM_DEPTH (WORK_RAM_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_if.action),
      .req_bus_address    (req_if.bus_address),
      .req_write_data     (req_if.write_data),
      .csr_we             (csr_if.valid),
      .csr_index          (csr_if.index),
      .csr_data           (csr_if.data),
      .rsp_status         (rsp_if.status),
      .rsp_mapped_address (rsp_if.mapped_address),
      .rsp_read_data      (rsp_if.read_data),
      .rsp_mirroring      (rsp_if.mirroring)
   );

endmodule
